// File: rtl/core/necird_pkg.sv
// Package for the NEC IR edge interval decoder.
// Holds the edge class codes, register indexes, reset values and shared types.
// No dependencies.
package necird_pkg;

  localparam int unsigned FrameBits = 32;
  localparam int unsigned BitCntW   = $clog2(FrameBits);
  localparam logic [31:0] LongBreakUs = 32'd20000;

  localparam logic [15:0] FullMinRst   = 16'd12000;
  localparam logic [15:0] FullMaxRst   = 16'd15000;
  localparam logic [15:0] RepeatMinRst = 16'd10000;
  localparam logic [15:0] RepeatMaxRst = 16'd12300;
  localparam logic [15:0] ZeroMinRst   = 16'd900;
  localparam logic [15:0] ZeroMaxRst   = 16'd1500;
  localparam logic [15:0] OneMinRst    = 16'd1800;
  localparam logic [15:0] OneMaxRst    = 16'd2900;

  typedef enum logic [2:0] {
    REG_FULL_MIN   = 3'd0,
    REG_FULL_MAX   = 3'd1,
    REG_REPEAT_MIN = 3'd2,
    REG_REPEAT_MAX = 3'd3,
    REG_ZERO_MIN   = 3'd4,
    REG_ZERO_MAX   = 3'd5,
    REG_ONE_MIN    = 3'd6,
    REG_ONE_MAX    = 3'd7
  } reg_idx_e;

  typedef enum logic [2:0] {
    CLS_NONE   = 3'd0,
    CLS_CLEAR  = 3'd1,
    CLS_REPEAT = 3'd2,
    CLS_LEADER = 3'd3,
    CLS_ZERO   = 3'd4,
    CLS_ONE    = 3'd5,
    CLS_OTHER  = 3'd6
  } cls_e;

  typedef struct packed {
    logic push;
    cls_e cls;
  } q_push_t;

  typedef struct packed {
    logic valid;
    cls_e cls;
  } q_head_t;

  function automatic logic in_win(logic [31:0] dt, logic [15:0] lo, logic [15:0] hi);
    return (dt >= {16'd0, lo}) && (dt <= {16'd0, hi});
  endfunction

endpackage

// File: rtl/core/nec_ir_edge_interval_decoder.sv
// Top level of the NEC IR edge interval decoder.
// Instantiates necird_front, necird_queue and necird_back; uses necird_pkg.
//
// Usage:
//   Input channel (in_valid_i/in_ready_o): one beat per falling edge, carrying
//   the microsecond timestamp and a lost-edge flag. Output channel
//   (out_valid_o/out_ready_i): one beat per decoded frame or repeat code.
//   Configuration: cfg_we_i writes cfg_wdata_i into window register
//   cfg_idx_i; write only while the block is idle.
//   Throughput: one edge beat per cycle while the queue is not full. The front
//   end subtracts the previous timestamp and classifies the interval in the
//   accept cycle; a two-entry class queue decouples it from the back end,
//   which updates the frame state and loads the result register.
//   Result path: the class of the edge that completes a result is written to
//   the queue, then popped into the result register, which holds until taken.
//   Reset: window registers take their default values, the previous-edge
//   record and the frame state clear, and no result is pending.
//   Stall: while a result waits on out_ready_i the back end takes no classes;
//   in_ready_o drops once the two-entry queue fills.
module nec_ir_edge_interval_decoder (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [15:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [31:0] edge_time_us_i,
  input  logic        edges_lost_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] frame_code_o,
  output logic        is_repeat_o
);

  necird_pkg::q_push_t q_push;
  necird_pkg::q_head_t q_head;
  logic                q_full;
  logic                q_pop;

  necird_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .edge_time_us_i (edge_time_us_i),
    .edges_lost_i   (edges_lost_i),
    .q_full_i       (q_full),
    .q_push_o       (q_push)
  );

  necird_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (q_push),
    .pop_i  (q_pop),
    .full_o (q_full),
    .head_o (q_head)
  );

  necird_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_i       (q_head),
    .pop_o        (q_pop),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .frame_code_o (frame_code_o),
    .is_repeat_o  (is_repeat_o)
  );

endmodule

// File: rtl/core/necird_front.sv
// Front end: accepts edge beats, holds the window registers and the previous
// timestamp, and classifies each interval. Depends on necird_pkg.
module necird_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [2:0]          cfg_idx_i,
  input  logic [15:0]         cfg_wdata_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [31:0]         edge_time_us_i,
  input  logic                edges_lost_i,
  input  logic                q_full_i,
  output necird_pkg::q_push_t q_push_o
);

  logic [15:0] full_min_q, full_max_q, rep_min_q, rep_max_q;
  logic [15:0] zero_min_q, zero_max_q, one_min_q, one_max_q;
  logic [31:0] prev_q;
  logic        have_prev_q;
  logic [31:0] dt;
  logic        accept;
  necird_pkg::cls_e cls;

  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && !q_full_i;
  assign dt         = edge_time_us_i - prev_q;

  always_comb begin
    priority if (edges_lost_i) begin
      cls = necird_pkg::CLS_CLEAR;
    end else if (!have_prev_q) begin
      cls = necird_pkg::CLS_NONE;
    end else if (dt > necird_pkg::LongBreakUs) begin
      cls = necird_pkg::CLS_CLEAR;
    end else if (necird_pkg::in_win(dt, rep_min_q, rep_max_q)) begin
      cls = necird_pkg::CLS_REPEAT;
    end else if (necird_pkg::in_win(dt, full_min_q, full_max_q)) begin
      cls = necird_pkg::CLS_LEADER;
    end else if (necird_pkg::in_win(dt, zero_min_q, zero_max_q)) begin
      cls = necird_pkg::CLS_ZERO;
    end else if (necird_pkg::in_win(dt, one_min_q, one_max_q)) begin
      cls = necird_pkg::CLS_ONE;
    end else begin
      cls = necird_pkg::CLS_OTHER;
    end
  end

  assign q_push_o.push = accept;
  assign q_push_o.cls  = cls;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q      <= '0;
      have_prev_q <= 1'b0;
    end else if (accept) begin
      prev_q      <= edge_time_us_i;
      have_prev_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      full_min_q <= necird_pkg::FullMinRst;
      full_max_q <= necird_pkg::FullMaxRst;
      rep_min_q  <= necird_pkg::RepeatMinRst;
      rep_max_q  <= necird_pkg::RepeatMaxRst;
      zero_min_q <= necird_pkg::ZeroMinRst;
      zero_max_q <= necird_pkg::ZeroMaxRst;
      one_min_q  <= necird_pkg::OneMinRst;
      one_max_q  <= necird_pkg::OneMaxRst;
    end else if (cfg_we_i) begin
      unique case (necird_pkg::reg_idx_e'(cfg_idx_i))
        necird_pkg::REG_FULL_MIN:   full_min_q <= cfg_wdata_i;
        necird_pkg::REG_FULL_MAX:   full_max_q <= cfg_wdata_i;
        necird_pkg::REG_REPEAT_MIN: rep_min_q  <= cfg_wdata_i;
        necird_pkg::REG_REPEAT_MAX: rep_max_q  <= cfg_wdata_i;
        necird_pkg::REG_ZERO_MIN:   zero_min_q <= cfg_wdata_i;
        necird_pkg::REG_ZERO_MAX:   zero_max_q <= cfg_wdata_i;
        necird_pkg::REG_ONE_MIN:    one_min_q  <= cfg_wdata_i;
        necird_pkg::REG_ONE_MAX:    one_max_q  <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

endmodule

// File: rtl/core/necird_queue.sv
// Two-entry queue of edge classes between front and back end.
// Depends on necird_pkg.
module necird_queue (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  necird_pkg::q_push_t push_i,
  input  logic                pop_i,
  output logic                full_o,
  output necird_pkg::q_head_t head_o
);

  necird_pkg::cls_e mem_q [2];
  logic       wptr_q, rptr_q;
  logic [1:0] cnt_q;
  logic       do_push, do_pop;

  assign full_o       = (cnt_q == 2'd2);
  assign head_o.valid = (cnt_q != 2'd0);
  assign head_o.cls   = mem_q[rptr_q];
  assign do_push      = push_i.push && !full_o;
  assign do_pop       = pop_i && head_o.valid;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= push_i.cls;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      if (do_push) wptr_q <= !wptr_q;
      if (do_pop)  rptr_q <= !rptr_q;
      cnt_q <= cnt_q + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

endmodule

// File: rtl/core/necird_back.sv
// Back end: frame state, bit accumulation and the result register.
// Depends on necird_pkg.
module necird_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  necird_pkg::q_head_t head_i,
  output logic                pop_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [31:0]         frame_code_o,
  output logic                is_repeat_o
);

  localparam int unsigned CntW = necird_pkg::BitCntW;
  localparam logic [CntW-1:0] LastBit = CntW'(necird_pkg::FrameBits - 1);

  logic            active_q, active_d;
  logic [31:0]     acc_q, acc_d;
  logic [CntW-1:0] bits_q, bits_d;
  logic            out_valid_q, out_valid_d;
  logic [31:0]     code_q, code_d;
  logic            rep_q, rep_d;
  logic [31:0]     acc_bit;

  assign pop_o   = head_i.valid && (!out_valid_q || out_ready_i);
  assign acc_bit = acc_q | (32'd1 << bits_q);

  always_comb begin
    active_d    = active_q;
    acc_d       = acc_q;
    bits_d      = bits_q;
    out_valid_d = out_valid_q && !out_ready_i;
    code_d      = code_q;
    rep_d       = rep_q;
    if (pop_o) begin
      unique case (head_i.cls)
        necird_pkg::CLS_NONE: ;
        necird_pkg::CLS_CLEAR, necird_pkg::CLS_OTHER: begin
          active_d = 1'b0;
          acc_d    = '0;
          bits_d   = '0;
        end
        necird_pkg::CLS_REPEAT: begin
          active_d    = 1'b0;
          acc_d       = '0;
          bits_d      = '0;
          out_valid_d = 1'b1;
          code_d      = '0;
          rep_d       = 1'b1;
        end
        necird_pkg::CLS_LEADER: begin
          active_d = 1'b1;
          acc_d    = '0;
          bits_d   = '0;
        end
        necird_pkg::CLS_ZERO, necird_pkg::CLS_ONE: begin
          if (active_q) begin
            if (bits_q == LastBit) begin
              active_d    = 1'b0;
              acc_d       = '0;
              bits_d      = '0;
              out_valid_d = 1'b1;
              code_d      = (head_i.cls == necird_pkg::CLS_ONE) ? acc_bit : acc_q;
              rep_d       = 1'b0;
            end else begin
              if (head_i.cls == necird_pkg::CLS_ONE) acc_d = acc_bit;
              bits_d = bits_q + 1'b1;
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q    <= 1'b0;
      acc_q       <= '0;
      bits_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      active_q    <= active_d;
      acc_q       <= acc_d;
      bits_q      <= bits_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    code_q <= code_d;
    rep_q  <= rep_d;
  end

  assign out_valid_o  = out_valid_q;
  assign frame_code_o = code_q;
  assign is_repeat_o  = rep_q;

endmodule
